// ===== hdl/stmf_pkg.sv =====
// Shared types and constants for the scaled trimmed-mean sensor filter.
// Payload structs, field widths and configuration register indexes.
// No dependencies.
package stmf_pkg;

    localparam int WINDOW_DEPTH_DEF = 8;

    localparam int SAMPLE_W   = 16;   // raw converter reading
    localparam int GAIN_W     = 15;
    localparam int DIV_W      = 16;   // divisor, also the divider's divisor width
    localparam int VALUE_W    = 31;   // scaled value, mean, threshold
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_sample;
        logic                controller_ready;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] filtered_value;
        logic               report;
    } t_out;

endpackage

// ===== hdl/scaled_trimmed_mean_sensor_filter.sv =====
// Top level of the scaled trimmed-mean sensor filter: window memory, shared
// restoring divider, walk sequencer and report tracking. Depends on stmf_pkg.
//
// Input (i_in_valid / o_in_ready / i_in_data): one raw sample and the
// controller-ready flag per transaction. Output (o_out_valid / i_out_ready /
// o_out_data): one filtered value and report flag per input, in order.
// Config: gain, divisor, change threshold via i_cfg_we / i_cfg_idx / i_cfg_data;
// written by the user only while idle, not enforced; unknown indexes are ignored.
// Processing: the product is registered into the shared divider, which yields
// one quotient bit per cycle (31 steps for scaling, 31 + log2(depth) for the
// mean), and the window walk reads each slot once. A zero divisor or an empty
// trim skips its division.
// Samples: one at a time; the next is accepted the cycle after the result is
// registered.
// Reset: synchronous, active low: window empty, write slot 0, no reported
// value, gain 1, divisor 1, threshold 0. No memory clearing pass is needed.
// Stall: the result waits in an output register; the next sample is taken and
// processed meanwhile, but the block holds in its final state until that
// register is free.
module scaled_trimmed_mean_sensor_filter #(
    parameter int WINDOW_DEPTH = stmf_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input transaction
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  stmf_pkg::t_in                    i_in_data,
    // output transaction
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output stmf_pkg::t_out                   o_out_data,
    // configuration writes
    input  logic                             i_cfg_we,
    input  logic [stmf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [stmf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int VW    = stmf_pkg::VALUE_W;
    localparam int DW    = stmf_pkg::DIV_W;
    localparam int AW    = $clog2(WINDOW_DEPTH);
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = VW + $clog2(WINDOW_DEPTH);
    localparam int DC_W  = $clog2(SUM_W + 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL    = 8'b0000_0010,  // product into divider
        S_DIVS   = 8'b0000_0100,  // scale division
        S_WRITE  = 8'b0000_1000,  // store scaled value
        S_WALK   = 8'b0001_0000,  // read every slot, track min/max/sum
        S_TRIM   = 8'b0010_0000,  // drop min and max, set up mean division
        S_DIVM   = 8'b0100_0000,  // mean division
        S_FINISH = 8'b1000_0000   // report decision, load output
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [stmf_pkg::GAIN_W-1:0]  r_gain;
    logic [DW-1:0]                r_divisor;
    logic [VW-1:0]                r_thr;

    // captured input transaction
    logic [stmf_pkg::SAMPLE_W-1:0] r_raw;
    logic                          r_ctrl;

    // shared restoring divider: r_dq shifts dividend out, quotient in
    logic [SUM_W-1:0] r_dq;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_dvs;
    logic [DC_W-1:0]  r_div_cnt;

    // window store
    logic [VW-1:0]           r_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] r_valid;
    logic [AW-1:0]           r_wslot;
    logic [VW-1:0]           r_rd_data;

    // walk
    logic [CW-1:0]    r_rd_cnt;
    logic             r_pend;
    logic [AW-1:0]    r_pend_idx;
    logic             r_found;
    logic [VW-1:0]    r_lo, r_hi;
    logic [AW-1:0]    r_lo_at, r_hi_at;
    logic [SUM_W-1:0] r_sum;
    logic [CW-1:0]    r_nval;

    // report tracking and output register
    logic [VW-1:0]  r_last;
    logic           r_last_vld;
    logic           r_out_vld;
    stmf_pkg::t_out r_out;

    logic in_fire;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // divider step
    logic [DW:0]   div_trial;
    logic          div_ge;
    logic [DW:0]   div_rem_nx;
    logic          div_last;
    assign div_trial  = {r_rem, r_dq[SUM_W-1]};
    assign div_ge     = (div_trial >= {1'b0, r_dvs});
    assign div_rem_nx = div_ge ? (div_trial - {1'b0, r_dvs}) : div_trial;
    assign div_last   = (r_div_cnt == DC_W'(1));

    // scaling product, registered into the divider
    logic [VW-1:0] prod;
    assign prod = VW'(r_raw) * VW'(r_gain);

    // walk read port
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    assign rd_en   = (r_state == S_WALK) && (r_rd_cnt != DEPTH_C);
    assign rd_addr = r_rd_cnt[AW-1:0];

    logic pend_use, take_lo, take_hi;
    assign pend_use = r_pend && r_valid[r_pend_idx];
    assign take_lo  = !r_found || (r_rd_data < r_lo);
    assign take_hi  = !r_found || (r_rd_data > r_hi);

    // trim: one slot dropped when min and max are the same slot, else two
    logic             trim_same;
    logic [CW-1:0]    trim_n;
    logic [SUM_W-1:0] trim_sum;
    assign trim_same = (r_lo_at == r_hi_at);
    assign trim_n    = r_nval - (trim_same ? CW'(1) : CW'(2));
    assign trim_sum  = r_sum - SUM_W'(r_lo) - (trim_same ? SUM_W'(0) : SUM_W'(r_hi));

    // report decision
    logic [VW-1:0] mean, diff;
    logic          report, out_free, fin_fire;
    assign mean     = r_dq[VW-1:0];
    assign diff     = (mean > r_last) ? (mean - r_last) : (r_last - mean);
    assign report   = r_ctrl && (!r_last_vld || (diff > r_thr));
    assign out_free = !r_out_vld || i_out_ready;
    assign fin_fire = (r_state == S_FINISH) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (in_fire) n_state = S_MUL;
            S_MUL:    n_state = (r_divisor == '0) ? S_WRITE : S_DIVS;
            S_DIVS:   if (div_last) n_state = S_WRITE;
            S_WRITE:  n_state = S_WALK;
            S_WALK:   if (!rd_en && !r_pend) n_state = S_TRIM;
            S_TRIM:   n_state = (trim_n == '0) ? S_FINISH : S_DIVM;
            S_DIVM:   if (div_last) n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_gain     <= stmf_pkg::GAIN_W'(1);
            r_divisor  <= DW'(1);
            r_thr      <= '0;
            r_valid    <= '0;
            r_wslot    <= '0;
            r_last_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    stmf_pkg::CFG_GAIN:      r_gain    <= i_cfg_data[stmf_pkg::GAIN_W-1:0];
                    stmf_pkg::CFG_DIVISOR:   r_divisor <= i_cfg_data[DW-1:0];
                    stmf_pkg::CFG_THRESHOLD: r_thr     <= i_cfg_data[VW-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_WRITE) begin
                r_valid[r_wslot] <= 1'b1;
                r_wslot <= (r_wslot == LAST_SLOT) ? '0 : r_wslot + 1'b1;
            end
            if (fin_fire) begin
                r_out_vld <= 1'b1;
                if (report) begin
                    r_last_vld <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // window memory: one write port, one registered read port. The write
    // happens in S_WRITE, all reads later in S_WALK, so they never overlap.
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_mem[r_wslot] <= r_dq[VW-1:0];
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_raw  <= i_in_data.raw_sample;
            r_ctrl <= i_in_data.controller_ready;
        end
        case (r_state)
            S_MUL: begin
                // product left-aligned so 31 steps leave the quotient in the low bits
                r_dq      <= (r_divisor == '0) ? '0 : {prod, {(SUM_W - VW){1'b0}}};
                r_rem     <= '0;
                r_dvs     <= r_divisor;
                r_div_cnt <= DC_W'(VW);
            end
            S_DIVS, S_DIVM: begin
                r_rem     <= div_rem_nx[DW-1:0];
                r_dq      <= {r_dq[SUM_W-2:0], div_ge};
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            S_WRITE: begin
                r_rd_cnt <= '0;
                r_pend   <= 1'b0;
                r_found  <= 1'b0;
                r_sum    <= '0;
                r_nval   <= '0;
            end
            S_WALK: begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_rd_cnt   <= r_rd_cnt + 1'b1;
                    r_pend_idx <= rd_addr;
                end
                if (pend_use) begin
                    r_found <= 1'b1;
                    r_sum   <= r_sum + SUM_W'(r_rd_data);
                    r_nval  <= r_nval + 1'b1;
                    if (take_lo) begin
                        r_lo    <= r_rd_data;
                        r_lo_at <= r_pend_idx;
                    end
                    if (take_hi) begin
                        r_hi    <= r_rd_data;
                        r_hi_at <= r_pend_idx;
                    end
                end
            end
            S_TRIM: begin
                r_dq      <= (trim_n == '0) ? '0 : trim_sum;
                r_rem     <= '0;
                r_dvs     <= DW'(trim_n);
                r_div_cnt <= DC_W'(SUM_W);
            end
            default: ;
        endcase
        if (fin_fire) begin
            r_out.filtered_value <= mean;
            r_out.report         <= report;
            if (report) begin
                r_last <= mean;
            end
        end
    end

`ifndef ASSERT_OFF
    // one sample in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("sample accepted while previous still in progress");

    // a new result appears only from the final state
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_FINISH))
        else $error("output valid raised outside final state");

    // window slots, once valid, stay valid (checked while walking)
    a_valid_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |=> ((r_valid & $past(r_valid)) == $past(r_valid)))
        else $error("window valid bit dropped");

    // divider never runs with an exhausted step count
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIVS) || (r_state == S_DIVM)) |-> (r_div_cnt != '0))
        else $error("divider step count underflow");
`endif

endmodule
